### hw/rtl/tdc_pkg.sv
package tdc_pkg;

	localparam int PAD_COUNT     = 4;
	localparam int PAD_SLOTS     = 4;
	localparam int SAMPLE_W      = 16;
	localparam int THR_W         = 17;
	localparam int THR_FRAC      = 16;
	localparam int TIME_W        = 32;
	localparam int PULSE_W       = 32;
	localparam int COST_W        = 32;
	localparam int TARGET_W      = 32;
	localparam int VOL_W         = 48;
	localparam int PROD_W        = PULSE_W + COST_W;
	localparam int INTERVAL_W    = 16;
	localparam int DECADE_W      = 4;
	localparam int VOLUME_PERIOD = 10;
	localparam int CFG_INDEX_W   = 3;
	localparam int CFG_DATA_W    = 32;

	localparam logic [TIME_W-1:0] MAX_RUN_MS = TIME_W'(600000);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BY_TIME_MODE,
		REG_SAMPLE_INTERVAL,
		REG_TOUCH_THRESHOLD,
		REG_IMPULSE_COST,
		REG_TARGET_ONE,
		REG_TARGET_TWO,
		REG_TARGET_THREE
	} cfg_reg_t;

	typedef struct packed {
		logic                by_time_mode;
		logic [TARGET_W-1:0] target_one;
		logic [TARGET_W-1:0] target_two;
		logic [TARGET_W-1:0] target_three;
	} drive_cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0]    time_now;
		logic [PAD_SLOTS-1:0] touched;
		logic [VOL_W-1:0]     volume;
	} drive_item_t;

	typedef struct packed {
		logic                 drive_on;
		logic [PAD_SLOTS-1:0] touch_flags;
		logic [VOL_W-1:0]     volume;
	} result_t;

endpackage

### hw/rtl/tdc_in_if.sv
interface tdc_in_if;
	import tdc_pkg::*;

	logic                valid;
	logic                ready;
	logic [TIME_W-1:0]   time_now;
	logic [SAMPLE_W-1:0] pad_zero;
	logic [SAMPLE_W-1:0] pad_one;
	logic [SAMPLE_W-1:0] pad_two;
	logic [SAMPLE_W-1:0] pad_three;
	logic [PULSE_W-1:0]  pulse_count;

	modport source (
		output valid, time_now, pad_zero, pad_one, pad_two, pad_three, pulse_count,
		input  ready
	);
	modport sink (
		input  valid, time_now, pad_zero, pad_one, pad_two, pad_three, pulse_count,
		output ready
	);
endinterface

### hw/rtl/tdc_out_if.sv
interface tdc_out_if;
	import tdc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 drive_on;
	logic [PAD_SLOTS-1:0] touch_flags;
	logic [VOL_W-1:0]     volume;

	modport source (
		output valid, drive_on, touch_flags, volume,
		input  ready
	);
	modport sink (
		input  valid, drive_on, touch_flags, volume,
		output ready
	);
endinterface

### hw/rtl/tdc_lane.sv
module tdc_lane (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic                         eval,
	input  logic [tdc_pkg::SAMPLE_W-1:0] sample,
	input  logic [tdc_pkg::THR_W-1:0]    threshold,
	output logic                         hit
);
	import tdc_pkg::*;

	localparam int BOUND_W = THR_W + SAMPLE_W;

	logic [SAMPLE_W-1:0] prev_q;
	logic [BOUND_W-1:0]  bound_s1;
	logic [SAMPLE_W-1:0] sample_s1;

	// reload the kept sample on every evaluating request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (take && eval) begin
			prev_q <= sample;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			bound_s1  <= BOUND_W'(threshold) * BOUND_W'(prev_q);
			sample_s1 <= sample;
		end
	end

	assign hit = BOUND_W'({sample_s1, {THR_FRAC{1'b0}}}) < bound_s1;
endmodule

### hw/rtl/tdc_drive.sv
module tdc_drive (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  tdc_pkg::drive_item_t item,
	input  tdc_pkg::drive_cfg_t  cfg,
	output logic                 res_valid,
	output tdc_pkg::result_t     res
);
	import tdc_pkg::*;

	logic                drive_q;
	logic [TARGET_W-1:0] target_q;
	logic [TIME_W-1:0]   start_time_q;
	logic [VOL_W-1:0]    start_vol_q;

	logic                start;
	logic [TARGET_W-1:0] start_target;
	logic                running;
	logic                stop;
	logic [TIME_W-1:0]   elapsed;
	logic [VOL_W-1:0]    vol_diff;
	logic                limit_hit;

	// lowest-numbered touched start pad wins
	always_comb begin
		start        = 1'b0;
		start_target = cfg.target_three;
		if (!drive_q) begin
			if (item.touched[1]) begin
				start        = 1'b1;
				start_target = cfg.target_one;
			end else if (item.touched[2]) begin
				start        = 1'b1;
				start_target = cfg.target_two;
			end else if (item.touched[3]) begin
				start        = 1'b1;
			end
		end
	end

	assign running  = drive_q || start;
	assign stop     = item.touched[0] && running;
	assign elapsed  = item.time_now - start_time_q;
	assign vol_diff = item.volume - start_vol_q;

	always_comb begin
		if (cfg.by_time_mode) begin
			limit_hit = elapsed > target_q;
		end else begin
			limit_hit = (item.volume > start_vol_q) &&
				(vol_diff > VOL_W'(target_q));
		end
		if (elapsed > MAX_RUN_MS) begin
			limit_hit = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q      <= 1'b0;
			target_q     <= '0;
			start_time_q <= '0;
			start_vol_q  <= '0;
		end else if (item_valid) begin
			if (stop) begin
				if (cfg.by_time_mode) begin
					target_q <= '0;
				end else if (start) begin
					target_q <= start_target;
				end
				start_time_q <= item.time_now;
				start_vol_q  <= item.volume;
				drive_q      <= 1'b0;
			end else if (start) begin
				// a fresh run has zero elapsed time and volume, so no limit applies yet
				target_q     <= start_target;
				start_time_q <= item.time_now;
				start_vol_q  <= item.volume;
				drive_q      <= 1'b1;
			end else if (drive_q && limit_hit) begin
				drive_q <= 1'b0;
			end
		end
	end

	assign res_valid       = item_valid;
	assign res.drive_on    = running && !stop;
	assign res.touch_flags = item.touched;
	assign res.volume      = item.volume;

	a_stop_drops_drive: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && stop |=> !drive_q)
		else $error("drive still on after stop pad");

	a_start_holds_drive: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !drive_q && res.drive_on |=> drive_q && start_time_q == $past(item.time_now))
		else $error("started run not recorded");
endmodule

### hw/rtl/tdc_fifo.sv
module tdc_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tdc_pkg::result_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output tdc_pkg::result_t pop_data
);
	import tdc_pkg::*;

	result_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 pop;

	assign pop       = pop_valid && pop_ready;
	assign pop_valid = count_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + FIFO_CW'(push) - FIFO_CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && count_q == FIFO_CW'(FIFO_DEPTH)))
		else $error("result queue overflow");

	a_pop_advances: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1)
		else $error("result queue count lost a pop");
endmodule

### hw/rtl/touch_dispense_controller_top.sv
// Touch-pad dispense controller.
// loop_in carries one control-loop request: a millisecond timestamp, four pad
// samples and the running flow-pulse count. loop_out returns exactly one result
// per request, in order: drive level, touch flags and dispensed volume (Q32.16).
// Write registers via wr_en/wr_index/wr_data only while no request is in flight;
// the block does not enforce it. Indexes beyond the register list are ignored.
// A result passes the s1 and s2 registers and the drive step into the output
// queue, and loop_out offers it from there.
// Throughput: one request per cycle while loop_in.ready is high. Four pad lanes
// judge the pads side by side and the volume product is registered, so the state
// per request (kept samples, touch flags, volume, run state) keeps pace.
// A four-entry output queue with a credit count decouples the sides: while
// loop_out stalls, requests are still taken until four are outstanding, then
// loop_in.ready drops until a result is taken.
// Reset clears all run state, kept samples, phases and the queue, and loads the
// registers with their defaults (interval 1, threshold 0.9, one litre a pulse).
module touch_dispense_controller_top (
	input  logic                            clk,
	input  logic                            arst_n,
	tdc_in_if.sink                          loop_in,
	tdc_out_if.source                       loop_out,
	input  logic                            wr_en,
	input  logic [tdc_pkg::CFG_INDEX_W-1:0] wr_index,
	input  logic [tdc_pkg::CFG_DATA_W-1:0]  wr_data
);
	import tdc_pkg::*;

	logic                  by_time_mode_q;
	logic [INTERVAL_W-1:0] sample_interval_q;
	logic [THR_W-1:0]      touch_threshold_q;
	logic [COST_W-1:0]     impulse_cost_q;
	logic [TARGET_W-1:0]   target_one_q;
	logic [TARGET_W-1:0]   target_two_q;
	logic [TARGET_W-1:0]   target_three_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			by_time_mode_q    <= 1'b0;
			sample_interval_q <= INTERVAL_W'(1);
			touch_threshold_q <= THR_W'(58982);
			impulse_cost_q    <= COST_W'(65536);
			target_one_q      <= '0;
			target_two_q      <= '0;
			target_three_q    <= '0;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_BY_TIME_MODE:    by_time_mode_q    <= wr_data[0];
				REG_SAMPLE_INTERVAL: sample_interval_q <= wr_data[INTERVAL_W-1:0];
				REG_TOUCH_THRESHOLD: touch_threshold_q <= wr_data[THR_W-1:0];
				REG_IMPULSE_COST:    impulse_cost_q    <= wr_data[COST_W-1:0];
				REG_TARGET_ONE:      target_one_q      <= wr_data[TARGET_W-1:0];
				REG_TARGET_TWO:      target_two_q      <= wr_data[TARGET_W-1:0];
				REG_TARGET_THREE:    target_three_q    <= wr_data[TARGET_W-1:0];
				default: ;
			endcase
		end
	end

	logic               take;
	logic               pop;
	logic [FIFO_CW-1:0] inflight_q;

	assign take          = loop_in.valid && loop_in.ready;
	assign pop           = loop_out.valid && loop_out.ready;
	assign loop_in.ready = inflight_q < FIFO_CW'(FIFO_DEPTH);

	// one credit per request until its result leaves the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + FIFO_CW'(take) - FIFO_CW'(pop);
		end
	end

	// evaluation and volume phases advance at acceptance
	logic [INTERVAL_W-1:0] phase_q;
	logic [DECADE_W-1:0]   decade_q;
	logic [INTERVAL_W-1:0] interval;
	logic [INTERVAL_W:0]   phase_inc;
	logic [DECADE_W:0]     decade_inc;
	logic                  eval;
	logic                  vol_due;

	assign interval   = (sample_interval_q == '0) ? INTERVAL_W'(1) : sample_interval_q;
	assign phase_inc  = {1'b0, phase_q} + 1'b1;
	assign decade_inc = {1'b0, decade_q} + 1'b1;
	assign eval       = phase_q == '0;
	assign vol_due    = decade_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			decade_q <= '0;
		end else if (take) begin
			phase_q  <= (phase_inc >= {1'b0, interval}) ? '0 : phase_inc[INTERVAL_W-1:0];
			decade_q <= (decade_inc >= (DECADE_W + 1)'(VOLUME_PERIOD)) ?
				'0 : decade_inc[DECADE_W-1:0];
		end
	end

	logic [SAMPLE_W-1:0]  samples [PAD_SLOTS];
	logic [PAD_SLOTS-1:0] hit;

	assign samples[0] = loop_in.pad_zero;
	assign samples[1] = loop_in.pad_one;
	assign samples[2] = loop_in.pad_two;
	assign samples[3] = loop_in.pad_three;

	for (genvar i = 0; i < PAD_SLOTS; i++) begin : g_lane
		if (i < PAD_COUNT) begin : g_pad
			tdc_lane u_lane (
				.clk       (clk),
				.arst_n    (arst_n),
				.take      (take),
				.eval      (eval),
				.sample    (samples[i]),
				.threshold (touch_threshold_q),
				.hit       (hit[i])
			);
		end else begin : g_none
			assign hit[i] = 1'b0;
		end
	end

	logic               valid_s1;
	logic               eval_s1;
	logic               vol_due_s1;
	logic [TIME_W-1:0]  now_s1;
	logic [PROD_W-1:0]  vprod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			eval_s1    <= eval;
			vol_due_s1 <= vol_due;
			now_s1     <= loop_in.time_now;
			vprod_s1   <= PROD_W'(loop_in.pulse_count) * PROD_W'(impulse_cost_q);
		end
	end

	// merge the lanes into the touch flags and saturate the volume
	logic                 valid_s2;
	logic [TIME_W-1:0]    now_s2;
	logic [PAD_SLOTS-1:0] touched_q;
	logic [VOL_W-1:0]     volume_q;
	logic [VOL_W-1:0]     vol_sat;

	assign vol_sat = (vprod_s1[PROD_W-1:VOL_W] != '0) ? {VOL_W{1'b1}} : vprod_s1[VOL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			touched_q <= '0;
			volume_q  <= '0;
		end else begin
			valid_s2 <= valid_s1;
			if (valid_s1 && eval_s1) begin
				touched_q <= hit;
			end
			if (valid_s1 && vol_due_s1) begin
				volume_q <= vol_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			now_s2 <= now_s1;
		end
	end

	drive_item_t item;
	drive_cfg_t  drive_cfg;
	logic        res_valid;
	result_t     res;
	result_t     out_data;

	assign item.time_now           = now_s2;
	assign item.touched            = touched_q;
	assign item.volume             = volume_q;
	assign drive_cfg.by_time_mode  = by_time_mode_q;
	assign drive_cfg.target_one    = target_one_q;
	assign drive_cfg.target_two    = target_two_q;
	assign drive_cfg.target_three  = target_three_q;

	tdc_drive u_drive (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s2),
		.item       (item),
		.cfg        (drive_cfg),
		.res_valid  (res_valid),
		.res        (res)
	);

	tdc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop_valid (loop_out.valid),
		.pop_ready (loop_out.ready),
		.pop_data  (out_data)
	);

	assign loop_out.drive_on    = out_data.drive_on;
	assign loop_out.touch_flags = out_data.touch_flags;
	assign loop_out.volume      = out_data.volume;

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= FIFO_CW'(FIFO_DEPTH) &&
		(inflight_q >= FIFO_CW'(valid_s1) + FIFO_CW'(valid_s2)))
		else $error("request credit count out of range");
endmodule

### dv/tb_touch_dispense_controller_top.sv
module tb_touch_dispense_controller_top;
	import tdc_pkg::*;

	localparam int PHASES     = 9;
	localparam int PHASE_REQS = 181;
	localparam int QUIET_MAX  = 5000;
	localparam logic [VOL_W-1:0] VOL_MAX = '1;

	typedef struct packed {
		logic [TIME_W-1:0]                    time_now;
		logic [PAD_SLOTS-1:0][SAMPLE_W-1:0]   pad;
		logic [PULSE_W-1:0]                   pulse_count;
	} loop_req_t;

	typedef struct packed {
		logic          is_cfg;
		cfg_reg_t      reg_sel;
		logic [31:0]   reg_val;
		loop_req_t     req;
		logic          typed;
		result_t       want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [CFG_INDEX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0]  wr_data;
	logic sink_ready = 1'b0;

	int in_idle_pct  = 33;
	int out_idle_pct = 48;
	bit failed = 1'b0;
	int unsigned quiet_cycles = 0;

	result_t pending_results[$];

	// dispenser state as the block should hold it
	logic                by_time_q    = 1'b0;
	logic [15:0]         interval_q   = 16'd1;
	logic [16:0]         threshold_q  = 17'd58982;
	logic [COST_W-1:0]   cost_q       = 32'd65536;
	logic [TARGET_W-1:0] pad_target [1:3] = '{32'd0, 32'd0, 32'd0};
	logic [15:0]         eval_phase   = '0;
	int                  decade_phase = 0;
	logic [SAMPLE_W-1:0] kept_level [PAD_SLOTS] = '{default: '0};
	logic [3:0]          touch_seen   = '0;
	logic [VOL_W-1:0]    volume_q     = '0;
	logic                motor_on     = 1'b0;
	logic [TIME_W-1:0]   run_t0       = '0;
	logic [VOL_W-1:0]    run_v0       = '0;
	logic [TARGET_W-1:0] run_limit    = '0;

	tdc_in_if  loop_in_bus ();
	tdc_out_if loop_out_bus ();

	assign loop_out_bus.ready = sink_ready;

	touch_dispense_controller_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.loop_in  (loop_in_bus),
		.loop_out (loop_out_bus),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #2 clk = ~clk;

	task automatic advance_dispenser(input loop_req_t r, output result_t res);
		logic [31:0] span;
		logic [31:0] elapsed;
		logic [63:0] raw_vol;
		logic        level;
		span = (interval_q == 16'd0) ? 32'd1 : 32'(interval_q);
		if (eval_phase == 16'd0) begin
			for (int p = 0; p < PAD_COUNT; p++) begin
				touch_seen[p] = (64'(r.pad[p]) << 16) < (64'(threshold_q) * 64'(kept_level[p]));
				kept_level[p] = r.pad[p];
			end
		end
		if (32'(eval_phase) + 32'd1 >= span)
			eval_phase = '0;
		else
			eval_phase = eval_phase + 16'd1;

		if (decade_phase == 0) begin
			raw_vol = 64'(r.pulse_count) * 64'(cost_q);
			volume_q = (raw_vol > 64'(VOL_MAX)) ? VOL_MAX : raw_vol[VOL_W-1:0];
		end
		decade_phase = (decade_phase + 1 >= VOLUME_PERIOD) ? 0 : decade_phase + 1;

		// lowest touched start pad wins
		for (int p = 1; p < PAD_SLOTS; p++) begin
			if (touch_seen[p] && !motor_on) begin
				run_limit = pad_target[p];
				run_t0 = r.time_now;
				run_v0 = volume_q;
				motor_on = 1'b1;
			end
		end
		if (touch_seen[0] && motor_on) begin
			if (by_time_q)
				run_limit = '0;
			run_v0 = volume_q;
			run_t0 = r.time_now;
			motor_on = 1'b0;
		end

		level = motor_on;
		if (motor_on) begin
			elapsed = r.time_now - run_t0;
			if (by_time_q) begin
				if (elapsed > run_limit)
					motor_on = 1'b0;
			end else if (volume_q > run_v0 && (volume_q - run_v0) > 48'(run_limit)) begin
				motor_on = 1'b0;
			end
			if (elapsed > MAX_RUN_MS)
				motor_on = 1'b0;
		end

		res.drive_on = level;
		res.touch_flags = touch_seen;
		res.volume = volume_q;
	endtask

	task automatic send_req(input loop_req_t r, input logic typed, input result_t want);
		result_t predicted;
		while ($urandom_range(0, 99) < in_idle_pct) begin
			loop_in_bus.valid <= 1'b0;
			@(posedge clk);
		end
		loop_in_bus.valid       <= 1'b1;
		loop_in_bus.time_now    <= r.time_now;
		loop_in_bus.pad_zero    <= r.pad[0];
		loop_in_bus.pad_one     <= r.pad[1];
		loop_in_bus.pad_two     <= r.pad[2];
		loop_in_bus.pad_three   <= r.pad[3];
		loop_in_bus.pulse_count <= r.pulse_count;
		do @(posedge clk); while (!loop_in_bus.ready);
		advance_dispenser(r, predicted);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// hold requests back until every result is home
	task automatic drain();
		loop_in_bus.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t sel, input logic [31:0] val);
		wr_en    <= 1'b1;
		wr_index <= sel;
		wr_data  <= val;
		@(posedge clk);
		case (sel)
			REG_BY_TIME_MODE:    by_time_q = val[0];
			REG_SAMPLE_INTERVAL: interval_q = val[15:0];
			REG_TOUCH_THRESHOLD: threshold_q = val[16:0];
			REG_IMPULSE_COST:    cost_q = val;
			REG_TARGET_ONE:      pad_target[1] = val;
			REG_TARGET_TWO:      pad_target[2] = val;
			REG_TARGET_THREE:    pad_target[3] = val;
			default: ;
		endcase
	endtask

	function automatic step_t req_row(logic [31:0] t, logic [15:0] p0, logic [15:0] p1,
			logic [15:0] p2, logic [15:0] p3, logic [31:0] pulses);
		step_t s;
		s = '0;
		s.req.time_now = t;
		s.req.pad = {p3, p2, p1, p0};
		s.req.pulse_count = pulses;
		return s;
	endfunction

	function automatic step_t cfg_row(cfg_reg_t sel, logic [31:0] val);
		step_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.reg_sel = sel;
		s.reg_val = val;
		return s;
	endfunction

	function automatic step_t pin(step_t s, result_t w);
		s.typed = 1'b1;
		s.want = w;
		return s;
	endfunction

	always @(posedge clk) begin : result_check
		result_t head;
		if (arst_n && loop_out_bus.valid && sink_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result drive_on %0d flags %h volume %h", $time,
					loop_out_bus.drive_on, loop_out_bus.touch_flags, loop_out_bus.volume);
				failed = 1'b1;
			end else begin
				head = pending_results.pop_front();
				if (loop_out_bus.drive_on !== head.drive_on) begin
					$display("%0t: drive_on expected %0d got %0d", $time,
						head.drive_on, loop_out_bus.drive_on);
					failed = 1'b1;
				end
				if (loop_out_bus.touch_flags !== head.touch_flags) begin
					$display("%0t: touch_flags expected %h got %h", $time,
						head.touch_flags, loop_out_bus.touch_flags);
					failed = 1'b1;
				end
				if (loop_out_bus.volume !== head.volume) begin
					$display("%0t: volume expected %h got %h", $time,
						head.volume, loop_out_bus.volume);
					failed = 1'b1;
				end
			end
		end
		sink_ready <= arst_n && ($urandom_range(0, 99) >= out_idle_pct);
	end

	always @(posedge clk) begin
		if ((loop_in_bus.valid && loop_in_bus.ready) || (loop_out_bus.valid && sink_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_MAX) begin
			$display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		step_t               plan[$];
		step_t               row;
		loop_req_t           r;
		logic                prev_cfg;
		logic                c_mode;
		logic [15:0]         c_interval;
		logic [16:0]         c_thr;
		logic [31:0]         c_cost;
		logic [31:0]         c_tgt [1:3];
		logic [31:0]         w_time;
		logic [31:0]         w_pulses;
		logic [15:0]         w_base [PAD_SLOTS];

		arst_n                  <= 1'b0;
		wr_en                   <= 1'b0;
		wr_index                <= REG_BY_TIME_MODE;
		wr_data                 <= '0;
		loop_in_bus.valid       <= 1'b0;
		loop_in_bus.time_now    <= '0;
		loop_in_bus.pad_zero    <= '0;
		loop_in_bus.pad_one     <= '0;
		loop_in_bus.pad_two     <= '0;
		loop_in_bus.pad_three   <= '0;
		loop_in_bus.pulse_count <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first evaluation sees no kept sample, so nothing is touched
		plan.push_back(pin(req_row(32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0),
			'{drive_on: 1'b0, touch_flags: 4'h0, volume: 48'd0}));
		// every pad drops: pad one starts, the stop pad ends it at once
		plan.push_back(pin(req_row(32'd10, 16'h0, 16'h0, 16'h0, 16'h0, 32'hFFFF_FFFF),
			'{drive_on: 1'b0, touch_flags: 4'hF, volume: 48'd0}));
		plan.push_back(pin(req_row(32'd20, 16'h0, 16'h0, 16'h0, 16'h0, 32'd0),
			'{drive_on: 1'b0, touch_flags: 4'h0, volume: 48'd0}));
		plan.push_back(req_row(32'd30, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'd5));
		plan.push_back(req_row(32'd40, 16'h8000, 16'h1000, 16'h0000, 16'h8000, 32'd5));
		// run outlasts the ten-minute guard
		plan.push_back(req_row(32'd600041, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'd5));
		plan.push_back(req_row(32'd600050, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'd5));
		plan.push_back(cfg_row(REG_BY_TIME_MODE, 32'd1));
		plan.push_back(cfg_row(REG_TARGET_TWO, 32'd100));
		plan.push_back(cfg_row(REG_TARGET_THREE, 32'hFFFF_FFFF));
		// pads two and three together, across the timestamp wrap
		plan.push_back(req_row(32'hFFFF_FFC0, 16'h8000, 16'h8000, 16'h1000, 16'h1000, 32'd5));
		plan.push_back(req_row(32'd20, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'd5));
		plan.push_back(req_row(32'd40, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'd5));
		plan.push_back(req_row(32'd50, 16'h1000, 16'h8000, 16'h8000, 16'h8000, 32'd5));
		plan.push_back(req_row(32'd60, 16'h8000, 16'h1000, 16'h8000, 16'h8000, 32'd5));
		plan.push_back(req_row(32'd70, 16'h1000, 16'h1000, 16'h8000, 16'h8000, 32'd5));
		plan.push_back(cfg_row(REG_BY_TIME_MODE, 32'd0));
		plan.push_back(cfg_row(REG_IMPULSE_COST, 32'hFFFF_FFFF));
		plan.push_back(cfg_row(REG_TOUCH_THRESHOLD, 32'd65536));
		plan.push_back(cfg_row(REG_SAMPLE_INTERVAL, 32'd0));
		plan.push_back(req_row(32'd80, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
		plan.push_back(req_row(32'd90, 16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
		plan.push_back(req_row(32'd100, 16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFE, 32'hFFFF_FFFF));
		plan.push_back(cfg_row(REG_SAMPLE_INTERVAL, 32'd5));
		plan.push_back(cfg_row(REG_TOUCH_THRESHOLD, 32'd0));
		plan.push_back(req_row(32'd110, 16'h0, 16'h0, 16'h0, 16'h0, 32'hFFFF_FFFF));
		plan.push_back(req_row(32'd120, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 32'hFFFF_FFFF));
		plan.push_back(req_row(32'd130, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 32'hFFFF_FFFF));
		plan.push_back(req_row(32'd140, 16'h0, 16'h0, 16'h0, 16'h0, 32'hFFFF_FFFF));
		// shrink the interval below the running phase
		plan.push_back(cfg_row(REG_SAMPLE_INTERVAL, 32'd2));
		plan.push_back(req_row(32'd150, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 32'hFFFF_FFFF));
		plan.push_back(req_row(32'd160, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 32'hFFFF_FFFF));
		plan.push_back(req_row(32'd170, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 32'hFFFF_FFFF));
		plan.push_back(req_row(32'd180, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 32'hFFFF_FFFF));

		prev_cfg = 1'b0;
		foreach (plan[k]) begin
			row = plan[k];
			if (row.is_cfg) begin
				if (!prev_cfg)
					drain();
				write_reg(row.reg_sel, row.reg_val);
			end else begin
				wr_en <= 1'b0;
				send_req(row.req, row.typed, row.want);
			end
			prev_cfg = row.is_cfg;
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < 3) begin
				in_idle_pct = 33;
				out_idle_pct = 48;
			end else if (ph < 6) begin
				in_idle_pct = 48;
				out_idle_pct = 33;
			end else begin
				in_idle_pct = 0;
				out_idle_pct = 0;
			end

			case (ph)
				0: begin
					c_mode = 1'b0;
					c_interval = 16'd1;
					c_thr = 17'd0;
					c_cost = 32'd0;
					c_tgt = '{32'd0, 32'd0, 32'd0};
				end
				1: begin
					c_mode = 1'b1;
					c_interval = 16'hFFFF;
					c_thr = 17'd65536;
					c_cost = 32'hFFFF_FFFF;
					c_tgt = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
				end
				default: begin
					c_mode = 1'($urandom_range(0, 1));
					case ($urandom_range(0, 7))
						0, 1: c_interval = 16'd1;
						2: c_interval = 16'($urandom_range(5, 40));
						default: c_interval = 16'($urandom_range(1, 4));
					endcase
					c_thr = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 65536))
						: 17'($urandom_range(52000, 65536));
					c_cost = $urandom_range(1, 32'h0004_0000);
					for (int p = 1; p <= 3; p++)
						c_tgt[p] = c_mode ? $urandom_range(0, 3000)
							: $urandom_range(0, 32'h0800_0000);
				end
			endcase

			drain();
			write_reg(REG_BY_TIME_MODE, {31'd0, c_mode});
			write_reg(REG_SAMPLE_INTERVAL, {16'd0, c_interval});
			write_reg(REG_TOUCH_THRESHOLD, {15'd0, c_thr});
			write_reg(REG_IMPULSE_COST, c_cost);
			write_reg(REG_TARGET_ONE, c_tgt[1]);
			write_reg(REG_TARGET_TWO, c_tgt[2]);
			write_reg(REG_TARGET_THREE, c_tgt[3]);
			wr_en <= 1'b0;

			w_time = $urandom;
			w_pulses = $urandom;
			for (int p = 0; p < PAD_SLOTS; p++)
				w_base[p] = 16'($urandom_range(16'h1000, 16'hFFFF));

			for (int n = 0; n < PHASE_REQS; n++) begin
				if (ph == 4 && n == PHASE_REQS / 2)
					drain();
				if ($urandom_range(0, 9) == 0) begin
					r.time_now = $urandom;
					r.pulse_count = $urandom;
					for (int p = 0; p < PAD_SLOTS; p++)
						r.pad[p] = 16'($urandom);
				end else begin
					// an occasional long gap can trip the run guard
					if ($urandom_range(0, 59) == 0)
						w_time = w_time + $urandom_range(100000, 700000);
					else
						w_time = w_time + $urandom_range(5, 30);
					if ($urandom_range(0, 39) == 0)
						w_pulses = w_pulses - $urandom_range(1, 600);
					else
						w_pulses = w_pulses + $urandom_range(0, 60);
					for (int p = 0; p < PAD_SLOTS; p++) begin
						r.pad[p] = w_base[p] - 16'($urandom_range(0, 255));
						if ($urandom_range(0, (p == 0) ? 24 : 11) == 0)
							r.pad[p] = w_base[p] >> $urandom_range(1, 3);
					end
					r.time_now = w_time;
					r.pulse_count = w_pulses;
				end
				send_req(r, 1'b0, '0);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0)
			$display("%0t: %0d results never arrived", $time, pending_results.size());
		if (!failed && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
